@@ rtl/core/fan_speed_tick_controller_macros.svh @@
// Assertion macros for the fan speed tick controller checker.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef FAN_SPEED_TICK_CONTROLLER_MACROS_SVH
`define FAN_SPEED_TICK_CONTROLLER_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define FSTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger
`define FSTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fstc_pkg.sv @@
// Shared types and constants of the fan speed tick controller.
// Used by the front, queue, back and top-level modules; depends on nothing.
package fstc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_DUTY = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_INTERVAL = 2'd2,
    CFG_PERIOD   = 2'd3
  } cfg_index_t;

  localparam int CFG_DATA_W = 17;

  // Reset values of the registers and of the debounce counter
  localparam logic [6:0]  MIN_DUTY_RESET = 7'd20;
  localparam logic [3:0]  DEBOUNCE_RESET = 4'd3;
  localparam logic [7:0]  INTERVAL_RESET = 8'd4;
  localparam logic [16:0] PERIOD_RESET   = 17'd1000;

  // Arithmetic constants
  localparam logic [6:0]  DUTY_MAX     = 7'd100;
  localparam logic [18:0] ROUND_BIAS   = 19'd2047;
  localparam logic [12:0] KNOB_FULL    = 13'd4095;
  localparam logic [7:0]  TICK_MAX     = 8'd255;
  // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT for any x below 2^24
  localparam logic [24:0] RECIP_100    = 25'd21474837;
  localparam int          RECIP_SHIFT  = 31;

  // Indicator level thresholds
  localparam logic [11:0] LEVEL_Q1 = 12'd1024;
  localparam logic [11:0] LEVEL_Q2 = 12'd2048;
  localparam logic [11:0] LEVEL_Q3 = 12'd3072;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Live configuration
  typedef struct packed {
    logic [6:0]  min_duty;
    logic [3:0]  debounce;
    logic [7:0]  interval;
    logic [16:0] period;
  } cfg_t;

  // Classified tick handed from front to back
  typedef struct packed {
    logic [11:0] adc;
    logic        clear;
    logic        sample;
    logic        running;
  } cmd_t;

  // Result word, fan_running in the lowest bit
  typedef struct packed {
    logic        sampled;
    logic [2:0]  level;
    logic [16:0] compare;
    logic [6:0]  duty;
    logic        running;
  } result_t;

endpackage

@@ rtl/core/fstc_front.sv @@
// Front end: debounces the button, toggles the fan and schedules samples.
// Depends on fstc_pkg; feeds classified ticks into fstc_queue.
module fstc_front import fstc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        button_raw,
  input  logic        remote_toggle,
  input  logic [11:0] adc_sample,
  output logic        push_valid,
  input  logic        push_ready,
  output cmd_t        push_cmd
);

  logic       running;
  logic [7:0] tick_count;
  logic       stable_level;
  logic       last_level;
  logic [3:0] same_count;

  logic       running_next;
  logic [7:0] tick_count_next;
  logic       stable_level_next;
  logic       last_level_next;
  logic [3:0] same_count_next;
  logic       rise;
  logic       toggle;
  logic       sample;
  logic [7:0] tick_base;
  logic [7:0] tick_inc;
  logic       accept;

  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  assign push_valid = in_valid;

  // Debounce the button and detect a filtered rising edge
  always_comb begin
    last_level_next   = last_level;
    same_count_next   = same_count;
    stable_level_next = stable_level;
    rise              = 1'b0;
    if (button_raw == last_level) begin
      if (same_count < cfg.debounce) begin
        same_count_next = same_count + 4'd1;
      end
    end else begin
      last_level_next = button_raw;
      same_count_next = 4'd1;
    end
    if (same_count_next >= cfg.debounce && stable_level != last_level_next) begin
      stable_level_next = last_level_next;
      rise              = last_level_next;
    end
  end

  // Toggle the fan and advance the saturating tick counter
  always_comb begin
    toggle       = rise || remote_toggle;
    running_next = running ^ toggle;
    tick_base    = (toggle && running_next) ? cfg.interval : tick_count;
    tick_inc     = (tick_base < TICK_MAX) ? tick_base + 8'd1 : tick_base;
    sample       = running_next && (tick_inc >= cfg.interval);
    tick_count_next = sample ? 8'd0 : tick_inc;
  end

  assign push_cmd.adc     = adc_sample;
  assign push_cmd.clear   = toggle && !running_next;
  assign push_cmd.sample  = sample;
  assign push_cmd.running = running_next;

  // Commit the front state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      tick_count   <= 8'd0;
      stable_level <= 1'b0;
      last_level   <= 1'b0;
      same_count   <= DEBOUNCE_RESET;
    end else if (accept) begin
      running      <= running_next;
      tick_count   <= tick_count_next;
      stable_level <= stable_level_next;
      last_level   <= last_level_next;
      same_count   <= same_count_next;
    end
  end

endmodule

@@ rtl/core/fstc_queue.sv @@
// Short flop queue of classified ticks between front and back.
// Depends on fstc_pkg for the command type and depth.
module fstc_queue import fstc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/fstc_back.sv @@
// Back end: maps knob samples to duty, compare and level; holds the output word.
// Depends on fstc_pkg; takes classified ticks from fstc_queue.
module fstc_back import fstc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  cmd_t    pop_cmd,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_QUOT  = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_RECIP = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t      state;
  logic [6:0]  duty_reg;
  logic [16:0] compare_reg;
  logic [2:0]  level_reg;
  logic [11:0] adc_hold;
  logic [18:0] prod;
  logic [6:0]  duty_new;
  logic [23:0] scaled;
  logic [48:0] recip;

  logic        out_free;
  logic        out_load;
  logic [6:0]  lo;
  logic [18:0] biased;
  logic [6:0]  q_est;
  logic [12:0] rem;
  logic [6:0]  quot;
  logic [7:0]  duty_sum;
  logic [6:0]  duty_calc;
  logic [16:0] compare_calc;
  logic [2:0]  level_calc;

  assign out_free  = !out_valid || out_ready;
  assign pop_ready = (state == ST_IDLE) && out_free;

  // Load the output word on a plain tick or at the end of a sample
  assign out_load = ((state == ST_IDLE) && pop_valid && out_free && !pop_cmd.sample) ||
                    ((state == ST_DONE) && out_free);

  // Clamp the minimum duty
  assign lo = (cfg.min_duty > DUTY_MAX) ? DUTY_MAX : cfg.min_duty;

  // Rounded divide by 4095: estimate by shift, then one correction step
  always_comb begin
    biased    = prod + ROUND_BIAS;
    q_est     = biased[18:12];
    rem       = {1'b0, biased[11:0]} + {6'd0, q_est};
    quot      = q_est + {6'd0, (rem >= KNOB_FULL)};
    duty_sum  = {1'b0, lo} + {1'b0, quot};
    duty_calc = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[6:0];
  end

  assign compare_calc = recip[RECIP_SHIFT +: 17];

  // Four-step indicator level from the knob quarter
  always_comb begin
    if (adc_hold < LEVEL_Q1) begin
      level_calc = 3'd1;
    end else if (adc_hold < LEVEL_Q2) begin
      level_calc = 3'd2;
    end else if (adc_hold < LEVEL_Q3) begin
      level_calc = 3'd3;
    end else begin
      level_calc = 3'd4;
    end
  end

  // Datapath registers of the sample sequence
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        adc_hold <= pop_cmd.adc;
        prod     <= {7'd0, pop_cmd.adc} * {12'd0, DUTY_MAX - lo};
      end
      ST_QUOT: begin
        duty_new <= duty_calc;
      end
      ST_SCALE: begin
        scaled <= {7'd0, cfg.period} * {17'd0, duty_new};
      end
      ST_RECIP: begin
        recip <= {25'd0, scaled} * {24'd0, RECIP_100};
      end
      default: begin
      end
    endcase
  end

  // Sequence the work and hold the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      duty_reg    <= 7'd0;
      compare_reg <= 17'd0;
      level_reg   <= 3'd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid && out_free) begin
            if (pop_cmd.sample) begin
              state <= ST_QUOT;
            end else begin
              // Tick without a sample: clear on switch-off, else repeat state
              if (pop_cmd.clear) begin
                duty_reg    <= 7'd0;
                compare_reg <= 17'd0;
                level_reg   <= 3'd0;
              end
              out_word.running <= pop_cmd.running;
              out_word.sampled <= 1'b0;
              out_word.duty    <= pop_cmd.clear ? 7'd0 : duty_reg;
              out_word.compare <= pop_cmd.clear ? 17'd0 : compare_reg;
              out_word.level   <= pop_cmd.clear ? 3'd0 : level_reg;
            end
          end
        end
        ST_QUOT: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_RECIP;
        end
        ST_RECIP: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Write back once the output word is free; a sample implies running
          if (out_free) begin
            if (duty_new != duty_reg) begin
              duty_reg    <= duty_new;
              compare_reg <= compare_calc;
            end
            level_reg        <= level_calc;
            out_word.running <= 1'b1;
            out_word.sampled <= 1'b1;
            out_word.duty    <= duty_new;
            out_word.compare <= (duty_new != duty_reg) ? compare_calc : compare_reg;
            out_word.level   <= level_calc;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/fan_speed_tick_controller.sv @@
// Top level of the fan speed tick controller: configuration registers and wiring
// of fstc_front, fstc_queue and fstc_back. Depends on fstc_pkg.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  s_tdata: button, remote toggle, ADC
//   m_*      out        m_tvalid / m_tready  m_tdata: running, duty, compare, level, sampled
//   cfg_*    in         cfg_we               cfg_index, cfg_data
//
// The front takes one word per cycle while the two-entry queue has room.
// The back handles a tick without a sample in its idle state, and a sampling tick
// in its chain of knob product, divide by 4095, period product and reciprocal
// product for the divide by 100, then write-back; it takes no new tick meanwhile.
// Reset is synchronous and active high; no clearing pass is needed.
// A stalled m_tready holds the output word while the front keeps filling the queue.
module fan_speed_tick_controller import fstc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // button_raw, remote_toggle, adc_sample[11:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // fan_running, duty_percent[6:0],
                                           // pwm_compare[16:0], speed_level[2:0], sampled
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    push_valid;
  logic    push_ready;
  cmd_t    push_cmd;
  logic    pop_valid;
  logic    pop_ready;
  cmd_t    pop_cmd;
  result_t out_word;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_duty <= MIN_DUTY_RESET;
      cfg.debounce <= DEBOUNCE_RESET;
      cfg.interval <= INTERVAL_RESET;
      cfg.period   <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIN_DUTY: cfg.min_duty <= cfg_data[6:0];
        CFG_DEBOUNCE: cfg.debounce <= cfg_data[3:0];
        CFG_INTERVAL: cfg.interval <= cfg_data[7:0];
        CFG_PERIOD:   cfg.period   <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  fstc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .button_raw    (s_tdata[0]),
    .remote_toggle (s_tdata[1]),
    .adc_sample    (s_tdata[13:2]),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  fstc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  fstc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tdata = {3'b000, out_word};

endmodule

@@ rtl/core/fstc_checker.sv @@
// Port-level checks of the fan speed tick controller, bound to the top level.
// Depends on fan_speed_tick_controller_macros.svh for the assertion macros.
`include "fan_speed_tick_controller_macros.svh"

module fstc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled output word holds
  `FSTC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

  // A stopped fan reports zero duty, compare and level
  `FSTC_ASSERT_NOW(a_off_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[27:1] == 27'd0, "stopped fan with non-zero outputs")

  // A sample is only taken while running and gives a level of one to four
  `FSTC_ASSERT_NOW(a_sample_level, clk, rst, m_tvalid && m_tdata[28], m_tdata[0] && (m_tdata[27:25] != 3'd0) && (m_tdata[27:25] <= 3'd4), "sample with bad level or fan stopped")

  // Duty never exceeds one hundred percent
  `FSTC_ASSERT_NOW(a_duty_cap, clk, rst, m_tvalid, m_tdata[7:1] <= 7'd100, "duty above one hundred percent")

endmodule

bind fan_speed_tick_controller fstc_checker u_fstc_checker (.*);

@@ dv/tb_fan_speed_tick_controller.sv @@
// Self-checking testbench for fan_speed_tick_controller: directed ticks, then random
// button, remote and knob streams under several register settings, with bursty input
// and a stalling sink. Depends on fstc_pkg and the block's RTL.
module tb_fan_speed_tick_controller;
  import fstc_pkg::*;

  localparam int N_DIRECTED      = 22;
  localparam int N_PHASES        = 8;
  localparam int TICKS_PER_PHASE = 210;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 400;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [31:0]      m_tdata;
  logic             cfg_we    = 1'b0;
  cfg_index_t       cfg_index = CFG_MIN_DUTY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fan_speed_tick_controller uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // button_raw, remote_toggle, adc_sample[11:0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // fan_running, duty_percent[6:0], pwm_compare[16:0],
                             // speed_level[2:0], sampled
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Settings the fan model runs with
  logic [6:0]  set_min;
  logic [3:0]  set_debounce;
  logic [7:0]  set_interval;
  logic [16:0] set_period;

  // Fan model state
  logic        fan_on;
  logic [7:0]  tick_cnt;
  logic        btn_stable;
  logic        btn_last;
  logic [3:0]  same_cnt;
  logic [6:0]  duty_q;
  logic [16:0] cmp_q;
  logic [2:0]  lvl_q;

  result_t pending_results[$];
  int      fails        = 0;
  int      results_seen = 0;
  int      sender_burst = 0;

  // Directed ticks; rows marked fixed carry their expected word inline
  typedef struct {
    logic        btn;
    logic        rem;
    logic [11:0] adc;
    bit          fixed;
    logic        run;
    logic [6:0]  duty;
    logic [16:0] cmp;
    logic [2:0]  lvl;
    logic        smp;
  } tick_row_t;

  tick_row_t directed_ticks [N_DIRECTED] = '{
    // idle after reset
    '{1'b0, 1'b0, 12'd0,    1'b1, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    // remote switch-on samples at once, minimum duty
    '{1'b0, 1'b1, 12'd0,    1'b1, 1'b1, 7'd20,  17'd200,  3'd1, 1'b1},
    '{1'b0, 1'b0, 12'd4095, 1'b1, 1'b1, 7'd20,  17'd200,  3'd1, 1'b0},
    '{1'b0, 1'b0, 12'd4095, 1'b1, 1'b1, 7'd20,  17'd200,  3'd1, 1'b0},
    '{1'b0, 1'b0, 12'd4095, 1'b1, 1'b1, 7'd20,  17'd200,  3'd1, 1'b0},
    // full knob at the interval
    '{1'b0, 1'b0, 12'd4095, 1'b1, 1'b1, 7'd100, 17'd1000, 3'd4, 1'b1},
    // remote switch-off clears everything
    '{1'b0, 1'b1, 12'd2048, 1'b1, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    // debounced press turns the fan on
    '{1'b1, 1'b0, 12'd2048, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b1, 1'b0, 12'd2048, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b1, 1'b0, 12'd2048, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b1, 1'b0, 12'd3071, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b1, 1'b1, 12'd3072, 1'b1, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    // release, then press and remote on the same tick count once
    '{1'b0, 1'b0, 12'd1023, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b0, 1'b0, 12'd1023, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b0, 1'b0, 12'd1023, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b1, 1'b0, 12'd1024, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b1, 1'b0, 12'd2047, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b1, 1'b1, 12'd2047, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b0, 1'b0, 12'd3072, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b0, 1'b0, 12'd1,    1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b0, 1'b0, 12'd4094, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0},
    '{1'b0, 1'b0, 12'd4094, 1'b0, 1'b0, 7'd0,   17'd0,    3'd0, 1'b0}
  };

  // Advance the fan model by one tick and return the word it produces
  function automatic result_t fan_tick(input logic btn, input logic rem,
                                       input logic [11:0] adc);
    result_t     r;
    logic        toggle;
    int unsigned lo;
    int unsigned knob;
    int unsigned d;
    toggle = rem;
    r      = '0;
    // debounce the button; only a filtered press toggles
    if (btn == btn_last) begin
      if (same_cnt < set_debounce) same_cnt = same_cnt + 4'd1;
    end else begin
      btn_last = btn;
      same_cnt = 4'd1;
    end
    if (same_cnt >= set_debounce && btn_stable != btn_last) begin
      btn_stable = btn_last;
      if (btn_stable) toggle = 1'b1;
    end
    if (toggle) begin
      fan_on = ~fan_on;
      if (fan_on) begin
        tick_cnt = set_interval;
      end else begin
        duty_q = '0;
        cmp_q  = '0;
        lvl_q  = '0;
      end
    end
    if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 8'd1;
    // sample the knob; compare only moves when the duty does
    if (fan_on && tick_cnt >= set_interval) begin
      lo   = (set_min > DUTY_MAX) ? 100 : set_min;
      knob = adc;
      d    = lo + (knob * (100 - lo) + 2047) / 4095;
      if (d > 100) d = 100;
      tick_cnt  = '0;
      r.sampled = 1'b1;
      if (d != duty_q) begin
        duty_q = d[6:0];
        cmp_q  = 17'((longint'(set_period) * d) / 100);
      end
      if (adc < LEVEL_Q1)      lvl_q = 3'd1;
      else if (adc < LEVEL_Q2) lvl_q = 3'd2;
      else if (adc < LEVEL_Q3) lvl_q = 3'd3;
      else                     lvl_q = 3'd4;
    end
    r.running = fan_on;
    r.duty    = duty_q;
    r.compare = cmp_q;
    r.level   = lvl_q;
    return r;
  endfunction

  // Offer one tick word, in bursts with random gaps, and log its expected result
  task automatic send_tick(input logic btn, input logic rem, input logic [11:0] adc,
                           input bit fixed, input result_t fixed_word);
    int      gap;
    result_t r;
    if (sender_burst == 0) begin
      sender_burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    sender_burst--;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, adc, rem, btn};
    do @(posedge clk); while (!s_tready);
    r = fan_tick(btn, rem, adc);
    pending_results.push_back(fixed ? fixed_word : r);
  endtask

  // One register write on the next edge
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      CFG_MIN_DUTY: set_min      = v[6:0];
      CFG_DEBOUNCE: set_debounce = v[3:0];
      CFG_INTERVAL: set_interval = v[7:0];
      default:      set_period   = v[16:0];
    endcase
  endtask

  // Stop offering and let every expected word come out
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("output word %h with nothing expected", m_tdata);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("fan_running",  want.running, got.running);
        check_field("duty_percent", want.duty,    got.duty);
        check_field("pwm_compare",  want.compare, got.compare);
        check_field("speed_level",  want.level,   got.level);
        check_field("sampled",      want.sampled, got.sampled);
      end
    end
  end

  // Sink pacing: segments of steady, random, sparse and toggling ready, plus one long hold-off
  initial begin : sink_pace
    int seg_len;
    int seg_mode;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      seg_len  = $urandom_range(5, 60);
      seg_mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        if (!held && results_seen >= HOLD_OFF_AFTER) begin
          held = 1'b1;
          m_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        case (seg_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  initial begin : stimulus
    int          k;
    int          p;
    int          hold_left;
    int          pick;
    logic        btn_level;
    logic        rem;
    logic [11:0] adc;
    logic [6:0]  new_min;
    logic [3:0]  new_deb;
    logic [7:0]  new_int;
    logic [16:0] new_per;
    result_t     fixed_word;

    // model starts from reset values
    set_min      = MIN_DUTY_RESET;
    set_debounce = DEBOUNCE_RESET;
    set_interval = INTERVAL_RESET;
    set_period   = PERIOD_RESET;
    fan_on       = 1'b0;
    tick_cnt     = '0;
    btn_stable   = 1'b0;
    btn_last     = 1'b0;
    same_cnt     = DEBOUNCE_RESET;
    duty_q       = '0;
    cmp_q        = '0;
    lvl_q        = '0;
    btn_level    = 1'b0;
    hold_left    = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (k = 0; k < N_DIRECTED; k++) begin
      fixed_word.running = directed_ticks[k].run;
      fixed_word.duty    = directed_ticks[k].duty;
      fixed_word.compare = directed_ticks[k].cmp;
      fixed_word.level   = directed_ticks[k].lvl;
      fixed_word.sampled = directed_ticks[k].smp;
      send_tick(directed_ticks[k].btn, directed_ticks[k].rem, directed_ticks[k].adc,
                directed_ticks[k].fixed, fixed_word);
    end

    // random part, one register setting per phase
    for (p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain_block();
        case (p)
          1: begin new_min = 7'd0;   new_deb = 4'd1;  new_int = 8'd1;   new_per = 17'd1; end
          2: begin new_min = 7'd100; new_deb = 4'd15; new_int = 8'd255; new_per = 17'd65536; end
          3: begin new_min = 7'd127; new_deb = 4'd0;  new_int = 8'd0;   new_per = 17'd0; end
          4: begin new_min = 7'd101; new_deb = 4'd2;  new_int = 8'd3;   new_per = 17'd131071; end
          default: begin
            new_min = 7'($urandom_range(0, 127));
            new_deb = 4'($urandom_range(0, 15));
            new_int = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 12));
            new_per = 17'($urandom_range(0, 131071));
          end
        endcase
        write_reg(CFG_MIN_DUTY, CFG_DATA_W'(new_min));
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(new_deb));
        write_reg(CFG_INTERVAL, CFG_DATA_W'(new_int));
        write_reg(CFG_PERIOD,   CFG_DATA_W'(new_per));
        cfg_we <= 1'b0;
      end
      for (k = 0; k < TICKS_PER_PHASE; k++) begin
        // button held for a random span, often long enough to pass the filter, with the odd glitch
        if (hold_left == 0) begin
          btn_level = ~btn_level;
          hold_left = ($urandom_range(0, 5) == 0) ? 1
                                                  : $urandom_range(1, set_debounce + 6);
        end
        hold_left--;
        rem  = ($urandom_range(0, 19) == 0);
        pick = $urandom_range(0, 7);
        case (pick)
          0: adc = 12'd0;
          1: adc = 12'd4095;
          2: begin
            case ($urandom_range(0, 2))
              0:       adc = LEVEL_Q1;
              1:       adc = LEVEL_Q2;
              default: adc = LEVEL_Q3;
            endcase
            adc = adc + 12'($urandom_range(0, 2)) - 12'd1;
          end
          default: adc = 12'($urandom_range(0, 4095));
        endcase
        send_tick(btn_level, rem, adc, 1'b0, '0);
      end
    end

    drain_block();
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ fan_speed_tick_controller.f @@
+incdir+rtl/core
rtl/core/fstc_pkg.sv
rtl/core/fstc_front.sv
rtl/core/fstc_queue.sv
rtl/core/fstc_back.sv
rtl/core/fan_speed_tick_controller.sv
rtl/core/fstc_checker.sv
dv/tb_fan_speed_tick_controller.sv
